[sv/ukst_pkg.sv]
// shared types and constants for the unordered key set table
package ukst_pkg;

  localparam int CAPACITY    = 128;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int REQ_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int LIM_W       = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [BYTE_W-1:0] LIMIT_RESET = BYTE_W'(128);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC
  } state_e;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic             append;
    logic             shift;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

endpackage

[sv/ukst_cell.sv]
// one cell of the key row: holds an entry, compares it and shifts it down
module ukst_cell (
  input  logic                             clk_i,
  input  logic [ukst_pkg::IDX_W-1:0]       idx_i,
  input  logic [ukst_pkg::KEY_W-1:0]       key_i,
  input  logic [ukst_pkg::KEY_W-1:0]       nbr_key_i,
  input  ukst_pkg::cell_ctl_t              ctl_i,
  output logic [ukst_pkg::KEY_W-1:0]       key_o,
  output logic                             match_o
);

  logic [ukst_pkg::KEY_W-1:0] entry_q, entry_d;
  logic                       match_q, match_d;
  logic                       in_use;

  // entry is live when below the count
  assign in_use  = ukst_pkg::CNT_W'(idx_i) < ctl_i.cnt;
  assign match_d = in_use && (entry_q == key_i);

  // append at the count, or take the upper neighbor at and above the hole
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.append && (ukst_pkg::CNT_W'(idx_i) == ctl_i.cnt)) begin
      entry_d = key_i;
    end else if (ctl_i.shift && (idx_i >= ctl_i.pos)) begin
      entry_d = nbr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign key_o   = entry_q;
  assign match_o = match_q;

endmodule

[sv/unordered_key_set_table.sv]
// top level of the unordered key set table: request control and the cell row
//
// Keeps a duplicate-free list of 32-bit keys packed from position 0, with a count.
// Input stream s_axis: one beat per request (lookup, insert if absent, remove).
// Output stream m_axis: one beat per request with success, position and count.
// Config: cfg_we_i writes the 8-bit key limit; write it only while idle.
// Each entry lives in a cell with its own comparator; a remove shifts the
// cells above the hole down by one, all in the same cycle.
// Order: the request beat is registered, the cells then register their
// compares, and the update then registers the result in the output register.
// A new request beat is taken only while idle or as the previous request
// commits; each request has a compare step and then an update step over the
// cell row.
// Reset: the count clears to zero and the limit returns to 128; the stored
// keys are not cleared and no sweep is needed.
// Stall: the result waits in the output register; a finished request holds
// its update cycle until that register is free, and s_axis_tready stays low
// meanwhile.
module unordered_key_set_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cfg
  input  logic                                cfg_we_i,
  input  logic [ukst_pkg::BYTE_W-1:0]         cfg_wdata_i,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] req_type, [33:2] key, [39:34] zero
  input  logic [ukst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] success, [8:1] position, [16:9] count_after, [23:17] zero
  output logic [ukst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int N = ukst_pkg::CAPACITY;

  ukst_pkg::state_e                    state_q, state_d;
  logic [ukst_pkg::REQ_W-1:0]          req_q, req_d;
  logic [ukst_pkg::KEY_W-1:0]          key_q, key_d;
  logic [ukst_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [ukst_pkg::BYTE_W-1:0]         limit_q, limit_d;
  logic                                out_vld_q, out_vld_d;
  logic [ukst_pkg::OUT_TDATA_W-1:0]    out_data_q, out_data_d;

  logic [N-1:0]                        match;
  logic [ukst_pkg::KEY_W-1:0]          cell_key [N];
  ukst_pkg::cell_ctl_t                 ctl;

  logic                                out_free;
  logic                                commit;
  logic                                accept;
  logic                                found;
  logic [ukst_pkg::IDX_W-1:0]          enc;
  logic                                ins_ok;
  logic                                rm_ok;
  logic                                ok;
  logic [ukst_pkg::CNT_W-1:0]          pos_full;
  logic [ukst_pkg::CNT_W-1:0]          cnt_new;

  // cell row
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [ukst_pkg::KEY_W-1:0] nbr;
    if (g == N - 1) begin : g_last
      assign nbr = cell_key[g];
    end else begin : g_mid
      assign nbr = cell_key[g+1];
    end
    ukst_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (ukst_pkg::IDX_W'(g)),
      .key_i     (key_q),
      .nbr_key_i (nbr),
      .ctl_i     (ctl),
      .key_o     (cell_key[g]),
      .match_o   (match[g])
    );
  end

  // one-hot match to position; keys are unique so at most one bit is set
  always_comb begin
    enc = '0;
    for (int i = 0; i < N; i++) begin
      enc = enc | (match[i] ? ukst_pkg::IDX_W'(i) : '0);
    end
  end

  // request outcome
  assign found    = |match;
  assign out_free = !out_vld_q || m_axis_tready;
  assign commit   = (state_q == ukst_pkg::ST_EXEC) && out_free;
  assign s_axis_tready = (state_q == ukst_pkg::ST_IDLE) || commit;
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ins_ok   = 1'b0;
    rm_ok    = 1'b0;
    ok       = 1'b0;
    pos_full = found ? ukst_pkg::CNT_W'(enc) : cnt_q;
    cnt_new  = cnt_q;
    case (req_q)
      ukst_pkg::REQ_LOOKUP: begin
        ok = found;
      end
      ukst_pkg::REQ_INSERT: begin
        ins_ok = !found && (cnt_q < ukst_pkg::CNT_W'(N))
                 && (ukst_pkg::LIM_W'(cnt_q) < ukst_pkg::LIM_W'(limit_q));
        ok     = ins_ok;
        if (ins_ok) begin
          cnt_new = cnt_q + ukst_pkg::CNT_W'(1);
        end
      end
      ukst_pkg::REQ_REMOVE: begin
        rm_ok = found;
        ok    = found;
        if (found) begin
          cnt_new = cnt_q - ukst_pkg::CNT_W'(1);
        end
      end
      default: begin
        pos_full = cnt_q;
      end
    endcase
  end

  // control to the cells
  always_comb begin
    ctl.append = commit && ins_ok;
    ctl.shift  = commit && rm_ok;
    ctl.pos    = enc;
    ctl.cnt    = cnt_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ukst_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = ukst_pkg::ST_MATCH;
      end
      ukst_pkg::ST_MATCH: begin
        state_d = ukst_pkg::ST_EXEC;
      end
      ukst_pkg::ST_EXEC: begin
        if (out_free) state_d = s_axis_tvalid ? ukst_pkg::ST_MATCH : ukst_pkg::ST_IDLE;
      end
      default: begin
        state_d = ukst_pkg::ST_IDLE;
      end
    endcase
  end

  // register updates
  always_comb begin
    req_d      = req_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    limit_d    = limit_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (accept) begin
      req_d = s_axis_tdata[1:0];
      key_d = s_axis_tdata[33:2];
    end
    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
    end
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (commit) begin
      cnt_d      = cnt_new;
      out_vld_d  = 1'b1;
      out_data_d = {7'd0, ukst_pkg::BYTE_W'(cnt_new), ukst_pkg::BYTE_W'(pos_full), ok};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ukst_pkg::ST_IDLE;
      cnt_q     <= '0;
      limit_q   <= ukst_pkg::LIMIT_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      limit_q   <= limit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
